// ----- rtl/bbl_pkg.sv -----
// Shared constants and types for the 9x9 box blur stream.
// No dependencies; imported by every rtl file of the block.
`timescale 1ns / 1ps
package bbl_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int RADIUS_DEF     = 4;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W = 24;

  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd1024;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  // per-word tag travelling down the pipe
  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

endpackage

// ----- rtl/bbl_vsum.sv -----
// Column stage: line memory holding the previous 2*RADIUS rows per column,
// and the vertical window sum. Depends on bbl_pkg.
`timescale 1ns / 1ps
module bbl_vsum #(
  parameter int MAX_WIDTH  = bbl_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS     = bbl_pkg::RADIUS_DEF,
  parameter int MAX_HEIGHT = bbl_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [bbl_pkg::PIX_W-1:0]                pix,
  input  logic [$clog2(MAX_HEIGHT+RADIUS+1)-1:0]   row,
  input  logic [$clog2(MAX_WIDTH)-1:0]             col,
  input  logic [$clog2(MAX_WIDTH)-1:0]             ocol,
  input  bbl_pkg::tag_t                            tag,
  output logic                                     v_valid,
  input  logic                                     v_ready,
  output logic [$clog2((2*RADIUS+1)*255+1)-1:0]    v_red,
  output logic [$clog2((2*RADIUS+1)*255+1)-1:0]    v_green,
  output logic [$clog2((2*RADIUS+1)*255+1)-1:0]    v_blue,
  output logic [$clog2(MAX_WIDTH)-1:0]             v_ocol,
  output bbl_pkg::tag_t                            v_tag
);
  import bbl_pkg::*;

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int ROWW  = $clog2(MAX_HEIGHT+RADIUS+1);
  localparam int VW    = $clog2((2*RADIUS+1)*255+1);
  localparam int WORDW = 2*RADIUS*PIX_W;

  logic [WORDW-1:0] mem [MAX_WIDTH];
  logic [WORDW-1:0] rd_word;
  logic [WORDW-1:0] wr_word;

  logic             s1v;
  logic [PIX_W-1:0] s1_pix;
  logic [ROWW-1:0]  s1_row;
  logic [COLW-1:0]  s1_col;
  logic [COLW-1:0]  s1_ocol;
  tag_t             s1_tag;
  logic             move;
  logic             load;

  assign move     = s1v && v_ready;
  assign in_ready = !s1v || v_ready;
  assign load     = in_valid && in_ready;
  assign wr_word  = {rd_word[WORDW-PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
    end else if (load) begin
      s1v <= 1'b1;
    end else if (move) begin
      s1v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_pix  <= pix;
      s1_row  <= row;
      s1_col  <= col;
      s1_ocol <= ocol;
      s1_tag  <= tag;
    end
  end

  // the word written this cycle bypasses the array
  always_ff @(posedge clk) begin
    if (move) begin
      mem[s1_col] <= wr_word;
    end
    if (load) begin
      rd_word <= (move && s1_col == col) ? wr_word : mem[col];
    end
  end

  // slot k holds row r-1-k; rows above the frame top are skipped
  always_comb begin
    v_red   = VW'(s1_pix[23:16]);
    v_green = VW'(s1_pix[15:8]);
    v_blue  = VW'(s1_pix[7:0]);
    for (int k = 0; k < 2*RADIUS; k++) begin
      if (s1_row > ROWW'(k)) begin
        v_red   = v_red   + VW'(rd_word[k*PIX_W+16 +: 8]);
        v_green = v_green + VW'(rd_word[k*PIX_W+8 +: 8]);
        v_blue  = v_blue  + VW'(rd_word[k*PIX_W +: 8]);
      end
    end
  end

  assign v_valid = s1v;
  assign v_ocol  = s1_ocol;
  assign v_tag   = s1_tag;

endmodule

// ----- rtl/bbl_hsum.sv -----
// Row stage: shift line of column sums, masked horizontal sum, divide by
// the window area and the output register. Depends on bbl_pkg.
`timescale 1ns / 1ps
module bbl_hsum #(
  parameter int MAX_WIDTH = bbl_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = bbl_pkg::RADIUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  v_valid,
  output logic                                  v_ready,
  input  logic [$clog2((2*RADIUS+1)*255+1)-1:0] v_red,
  input  logic [$clog2((2*RADIUS+1)*255+1)-1:0] v_green,
  input  logic [$clog2((2*RADIUS+1)*255+1)-1:0] v_blue,
  input  logic [$clog2(MAX_WIDTH)-1:0]          v_ocol,
  input  bbl_pkg::tag_t                         v_tag,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_red,
  output logic [7:0]                            out_green,
  output logic [7:0]                            out_blue,
  output logic                                  frame_end
);
  import bbl_pkg::*;

  localparam int WIN   = 2*RADIUS+1;
  localparam int AREA  = WIN*WIN;
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int VW    = $clog2(WIN*255+1);
  localparam int SUMW  = $clog2(AREA*255+1);
  localparam int SH    = SUMW + $clog2(AREA);
  localparam int RECIP = ((1 << SH) + AREA - 1) / AREA;
  localparam int PW    = SUMW + $clog2(RECIP+1);

  logic [VW-1:0]   hr [WIN];
  logic [VW-1:0]   hg [WIN];
  logic [VW-1:0]   hb [WIN];
  logic            s2v;
  logic            s2_last;
  logic [COLW-1:0] s2_ocol;

  logic            s3v;
  logic            s3_last;
  logic [SUMW-1:0] s3_r, s3_g, s3_b;
  logic [SUMW-1:0] sum_r, sum_g, sum_b;
  logic [PW-1:0]   prod_r, prod_g, prod_b;

  logic o_free, s3_free, s2_free, shift;

  assign o_free  = !out_valid || !out_stall;
  assign s3_free = !s3v || o_free;
  assign s2_free = !s2v || s3_free;
  assign v_ready = s2_free;
  assign shift   = v_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2v       <= 1'b0;
      s3v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (shift) begin
        s2v <= v_tag.emit;
      end else if (s3_free) begin
        s2v <= 1'b0;
      end
      if (s2v && s3_free) begin
        s3v <= 1'b1;
      end else if (o_free) begin
        s3v <= 1'b0;
      end
      if (s3v && o_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // newest column sum at tap 0
  always_ff @(posedge clk) begin
    if (shift) begin
      hr[0] <= v_red;
      hg[0] <= v_green;
      hb[0] <= v_blue;
      for (int j = 1; j < WIN; j++) begin
        hr[j] <= hr[j-1];
        hg[j] <= hg[j-1];
        hb[j] <= hb[j-1];
      end
      s2_last <= v_tag.last;
      s2_ocol <= v_ocol;
    end
  end

  // tap j sits at column ocol+RADIUS-j; columns off the row are black
  always_comb begin
    int d;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int j = 0; j < WIN; j++) begin
      d = int'(s2_ocol) + RADIUS - j;
      if (d >= 0 && d < int'(w_eff)) begin
        sum_r = sum_r + SUMW'(hr[j]);
        sum_g = sum_g + SUMW'(hg[j]);
        sum_b = sum_b + SUMW'(hb[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2v && s3_free) begin
      s3_r    <= sum_r;
      s3_g    <= sum_g;
      s3_b    <= sum_b;
      s3_last <= s2_last;
    end
  end

  // divide by area: multiply by rounded-up reciprocal, exact over the range
  assign prod_r = PW'(s3_r) * PW'(RECIP);
  assign prod_g = PW'(s3_g) * PW'(RECIP);
  assign prod_b = PW'(s3_b) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (s3v && o_free) begin
      out_red   <= prod_r[SH +: 8];
      out_green <= prod_g[SH +: 8];
      out_blue  <= prod_b[SH +: 8];
      frame_end <= s3_last;
    end
  end

endmodule

// ----- rtl/box_blur_9x9_stream.sv -----
// Streaming 9x9 box blur, zero padded, RGB raster in, raster out.
// The word completing a window yields its result via the column, shift, sum and output registers.
// Throughput: one word per cycle while out_stall is low; input stalls after reset or a
// register write, and for 4*width+4-width*height black filler words when a frame is shorter.
// Reset clears counters and pipe; registers return to 1024 x 1024.
// Line memory needs no clearing pass: rows above the top are masked.
`timescale 1ns / 1ps
module box_blur_9x9_stream #(
  parameter int MAX_WIDTH  = bbl_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS     = bbl_pkg::RADIUS_DEF,
  parameter int MAX_HEIGHT = bbl_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bbl_pkg::*;

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int HW   = $clog2(MAX_HEIGHT+1);
  localparam int ROWW = $clog2(MAX_HEIGHT+RADIUS+1);
  localparam int CNTW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int VW   = $clog2((2*RADIUS+1)*255+1);

  logic [10:0]     image_width;
  logic [12:0]     image_height;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [CNTW-1:0] total;
  logic [CNTW-1:0] lag;
  logic            settle;

  logic [ROWW-1:0] in_row;
  logic [COLW-1:0] in_col;
  logic [HW-1:0]   out_row;
  logic [COLW-1:0] out_col;
  logic [CNTW-1:0] items_seen;
  logic [CNTW-1:0] filled;

  logic     wr, acc, is_pix, take_pix, emit, enter, last, v_in_ready;
  logic     fill_req, fill_go, feed;
  reg_idx_t idx;
  tag_t     tag;
  logic [PIX_W-1:0] pix;

  logic            v_valid, v_ready;
  logic [VW-1:0]   v_red, v_green, v_blue;
  logic [COLW-1:0] v_ocol;
  tag_t            v_tag;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      settle       <= 1'b1;
    end else begin
      settle <= wr;
      if (wr && idx == REG_WIDTH) begin
        image_width <= pwdata[10:0];
      end
      if (wr && idx == REG_HEIGHT) begin
        image_height <= pwdata[12:0];
      end
    end
  end

  // clamped geometry, registered from image_width and image_height after any write
  always_ff @(posedge clk) begin
    if (image_width == '0) begin
      w_eff <= WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff <= WW'(MAX_WIDTH);
    end else begin
      w_eff <= WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff <= HW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff <= HW'(MAX_HEIGHT);
    end else begin
      h_eff <= HW'(image_height);
    end
  end

  assign total = CNTW'(w_eff) * CNTW'(h_eff);
  assign lag   = CNTW'(w_eff) * CNTW'(RADIUS) + CNTW'(RADIUS);

  // short frame: pad with black words until the pipe is lag words ahead
  assign fill_req = items_seen >= total && (total + filled) < lag;
  assign fill_go  = fill_req && !settle && v_in_ready;

  assign in_stall = settle || !v_in_ready || fill_req;
  assign acc      = in_valid && !in_stall;
  assign is_pix   = req_t'(req_type) == REQ_PIXEL;
  assign take_pix = is_pix && items_seen < total;
  // drain words are black pixels past the bottom edge
  assign emit     = take_pix ? (items_seen >= lag) : (!is_pix && items_seen >= total);
  assign enter    = take_pix || emit;
  assign feed     = (acc && enter) || fill_go;
  assign last     = emit && out_row == HW'(h_eff - 1'b1)
                         && out_col == COLW'(w_eff - 1'b1);
  assign tag      = '{emit: acc && emit, last: acc && last};
  assign pix      = (acc && is_pix) ? {in_red, in_green, in_blue} : '0;

  always_ff @(posedge clk) begin
    if (rst || wr || (acc && last)) begin
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      items_seen <= '0;
      filled     <= '0;
    end else if (feed) begin
      if (in_col == COLW'(w_eff - 1'b1)) begin
        in_col <= '0;
        in_row <= in_row + 1'b1;
      end else begin
        in_col <= in_col + 1'b1;
      end
      if (acc && take_pix) begin
        items_seen <= items_seen + 1'b1;
      end
      if (acc && emit) begin
        if (out_col == COLW'(w_eff - 1'b1)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      if (fill_go) begin
        filled <= filled + 1'b1;
      end
    end
  end

  bbl_vsum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .RADIUS     (RADIUS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_vsum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed),
    .in_ready (v_in_ready),
    .pix      (pix),
    .row      (in_row),
    .col      (in_col),
    .ocol     (out_col),
    .tag      (tag),
    .v_valid  (v_valid),
    .v_ready  (v_ready),
    .v_red    (v_red),
    .v_green  (v_green),
    .v_blue   (v_blue),
    .v_ocol   (v_ocol),
    .v_tag    (v_tag)
  );

  bbl_hsum #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_hsum (
    .clk       (clk),
    .rst       (rst),
    .v_valid   (v_valid),
    .v_ready   (v_ready),
    .v_red     (v_red),
    .v_green   (v_green),
    .v_blue    (v_blue),
    .v_ocol    (v_ocol),
    .v_tag     (v_tag),
    .w_eff     (w_eff),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    wr |=> (items_seen == '0 && out_row == '0 && out_col == '0 && in_row == '0))
    else $error("counters not cleared by register write");

  a_early_drain: assert property (@(posedge clk) disable iff (rst)
    (acc && !is_pix && items_seen < total && !wr) |=> $stable(items_seen))
    else $error("early drain word changed the pixel count");

  a_settle_stall: assert property (@(posedge clk) disable iff (rst)
    wr |=> in_stall)
    else $error("word accepted before geometry settled");

endmodule
